FILE: rtl/vsa_pkg.sv
// Shared types and constants for the versioned slot allocator.
package vsa_pkg;

  localparam int OWNER_W    = 8;
  localparam int SLOT_IN_W  = 20;
  localparam int VER_W      = 16;
  localparam int PAY_W      = 32;
  localparam int HSLOT_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 2;
  localparam int OP_W       = 2;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam int SLOTS_DEF        = 1024;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  localparam logic [ADDR_W-1:0] REG_OWNER_ADDR = 3'd0;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_LOOKUP,
    K_RELEASE,
    K_REJECT
  } kind_t;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [SLOT_IN_W-1:0] slot_index;
    logic [VER_W-1:0]     slot_version;
    logic [PAY_W-1:0]     payload;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OWNER_W-1:0]  owner;
    logic [HSLOT_W-1:0]  handle_slot;
    logic [VER_W-1:0]    handle_version;
    logic [PAY_W-1:0]    found_payload;
    logic [COUNT_W-1:0]  active_count;
  } result_t;

  typedef struct packed {
    kind_t                kind;
    logic [SLOT_IN_W-1:0] slot;
    logic [VER_W-1:0]     version;
    logic [PAY_W-1:0]     payload;
  } cmd_t;

endpackage

FILE: rtl/vsa_fifo.sv
// Two-entry word queue with push/full and pop/empty sides.
module vsa_fifo import vsa_pkg::*; #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] ent [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= din;
    end
  end

endmodule

FILE: rtl/vsa_front.sv
// Front end: accept input words, classify them and queue commands.
module vsa_front import vsa_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item,
  output logic  full,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_pop
);

  cmd_t             cls;
  logic             in_range;
  logic [PAY_W-1:0] pay_m;
  logic             cmd_empty;

  always_comb begin
    pay_m = '0;
    for (int b = 0; b < PAY_W; b++) begin
      if (b < PAYLOAD_BITS) begin
        pay_m[b] = item.payload[b];
      end
    end
  end

  assign in_range = ({1'b0, item.slot_index} < (SLOT_IN_W + 1)'(SLOTS));

  always_comb begin
    cls.slot    = item.slot_index;
    cls.version = item.slot_version;
    cls.payload = pay_m;
    case (item.operation)
      OP_ALLOC:   cls.kind = K_ALLOC;
      OP_LOOKUP:  cls.kind = in_range ? K_LOOKUP : K_REJECT;
      OP_RELEASE: cls.kind = (in_range && pay_m != '0) ? K_RELEASE : K_REJECT;
      default:    cls.kind = K_REJECT;
    endcase
  end

  vsa_fifo #(.W($bits(cmd_t))) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cls),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

FILE: rtl/vsa_back.sv
// Back end: slot record memory, free list and result queue.
module vsa_back import vsa_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [OWNER_W-1:0] owner_index,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output result_t            result
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PW = PAYLOAD_BITS;

  typedef enum logic [1:0] {
    S_READ = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic             mem_active [SLOTS];
  logic [VER_W-1:0] mem_gen    [SLOTS];
  logic [PW-1:0]    mem_pay    [SLOTS];
  logic [CW-1:0]    mem_link   [SLOTS];

  logic [CW-1:0] list_head;
  logic [CW-1:0] list_head_next;
  logic [CW-1:0] fresh;
  logic [CW-1:0] fresh_next;
  logic [CW-1:0] used;
  logic [CW-1:0] used_next;

  logic [SW-1:0]    rd_addr;
  logic             rd_new;
  logic             rd_active;
  logic [VER_W-1:0] rd_gen;
  logic [PW-1:0]    rd_pay;
  logic [CW-1:0]    rd_link;

  logic [SW-1:0] addr;
  logic          go;
  logic          res_full;
  logic          res_push;
  result_t       res;

  logic             act;
  logic [VER_W-1:0] gen;
  logic [PW-1:0]    cmd_pay;

  logic             we_active;
  logic             active_wdata;
  logic             we_gen;
  logic [VER_W-1:0] gen_wdata;
  logic             we_pay;
  logic             we_link;

  assign addr    = (cmd.kind == K_ALLOC) ? list_head[SW-1:0] : cmd.slot[SW-1:0];
  assign go      = (state == S_READ) && cmd_valid && !res_full;
  assign cmd_pay = PW'(cmd.payload);
  assign act     = !rd_new && rd_active;
  assign gen     = rd_new ? '0 : rd_gen;

  always_comb begin
    state_next     = state;
    list_head_next = list_head;
    fresh_next     = fresh;
    used_next      = used;
    res_push       = 1'b0;
    cmd_pop        = 1'b0;
    we_active      = 1'b0;
    active_wdata   = 1'b0;
    we_gen         = 1'b0;
    gen_wdata      = gen;
    we_pay         = 1'b0;
    we_link        = 1'b0;
    res            = '0;
    res.status     = ST_MISS;
    case (state)
      S_READ: begin
        if (go) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_READ;
        res_push   = 1'b1;
        cmd_pop    = 1'b1;
        case (cmd.kind)
          K_ALLOC: begin
            if (list_head == CW'(SLOTS)) begin
              res.status = ST_FULL;
            end else begin
              we_active          = 1'b1;
              active_wdata       = 1'b1;
              we_gen             = 1'b1;
              we_pay             = 1'b1;
              list_head_next     = rd_new ? list_head + 1'b1 : rd_link;
              fresh_next         = rd_new ? fresh + 1'b1 : fresh;
              used_next          = used + 1'b1;
              res.status         = ST_OK;
              res.owner          = owner_index;
              res.handle_slot    = HSLOT_W'(list_head);
              res.handle_version = gen;
            end
          end
          K_LOOKUP: begin
            if (act && gen == cmd.version && rd_pay != '0) begin
              res.status        = ST_OK;
              res.found_payload = PAY_W'(rd_pay);
            end
          end
          K_RELEASE: begin
            if (act && rd_pay == cmd_pay) begin
              we_active      = 1'b1;
              we_gen         = 1'b1;
              gen_wdata      = gen + 1'b1;
              we_link        = 1'b1;
              list_head_next = CW'(rd_addr);
              used_next      = used - 1'b1;
              res.status     = ST_OK;
            end
          end
          default: begin
            res.status = ST_MISS;
          end
        endcase
        res.active_count = COUNT_W'(used_next);
      end
      default: begin
        state_next = S_READ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_READ;
      list_head <= '0;
      fresh     <= '0;
      used      <= '0;
    end else begin
      state     <= state_next;
      list_head <= list_head_next;
      fresh     <= fresh_next;
      used      <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rd_addr   <= addr;
      rd_new    <= (CW'(addr) >= fresh);
      rd_active <= mem_active[addr];
      rd_gen    <= mem_gen[addr];
      rd_pay    <= mem_pay[addr];
      rd_link   <= mem_link[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_active) begin
      mem_active[rd_addr] <= active_wdata;
    end
    if (we_gen) begin
      mem_gen[rd_addr] <= gen_wdata;
    end
    if (we_pay) begin
      mem_pay[rd_addr] <= cmd_pay;
    end
    if (we_link) begin
      mem_link[rd_addr] <= list_head;
    end
  end

  vsa_fifo #(.W($bits(result_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

FILE: rtl/versioned_slot_allocator.sv
// Top level of the versioned slot allocator: register port and front/back hookup.
//
// Handle table with a free list and a version number per slot.
// Input side: drive item and raise push; a word is taken on a clock edge with
// push high and full low. operation selects allocate, look up or release.
// Result side: while empty is low the oldest result sits on result; raise pop
// to take it. Exactly one result word comes back for every input word, in order.
// The user must write owner_index over the APB port at address 0 only while the
// block is idle; the block itself does not enforce this. The back end handles
// one word at a time by a read-modify-write of the slot record memory: it reads
// the record into registers in its read state, then updates and writes it back
// in its execute state, which also pushes the result into the result queue.
// Reset: the free list starts as 0, 1, 2, ...; a high-water counter stands in
// for never-touched slots, so no clearing pass runs and words are taken at once.
// Stalls: two-entry queues sit at the input and at the output; while the
// receiver holds off, the back end stops once the result queue fills and full
// rises once the command queue fills.
module versioned_slot_allocator import vsa_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  item_t             item,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [OWNER_W-1:0] owner_index;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_OWNER_ADDR) ? DATA_W'(owner_index) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_index <= '0;
    end else if (psel && penable && pwrite && paddr == REG_OWNER_ADDR) begin
      owner_index <= pwdata[OWNER_W-1:0];
    end
  end

  vsa_front #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  vsa_back #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .owner_index (owner_index),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for the versioned slot allocator: directed, random and slot reuse tests.
module tb;
  import vsa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 6;
  localparam int REUSE_ROUNDS  = 24;

  logic              clk;
  logic              rst;
  logic              push;
  item_t             in_word;
  logic              full;
  logic              empty;
  logic              pop = 1'b0;
  result_t           out_word;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [COUNT_W-1:0] next_link  [SLOTS_DEF];
  logic               in_use     [SLOTS_DEF];
  logic [VER_W-1:0]   version_of [SLOTS_DEF];
  logic [PAY_W-1:0]   held_ref   [SLOTS_DEF];
  logic [COUNT_W-1:0] head_free;
  logic [COUNT_W-1:0] live_count;
  logic [OWNER_W-1:0] owner_reg;

  result_t pending_results [$];
  int      send_idle;
  int      recv_idle;
  int      mismatches;
  int      cycle_count;

  versioned_slot_allocator u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (in_word),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .result  (out_word),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic result_t table_step(item_t w);
    result_t r;
    int      s;
    r = '0;
    r.status = ST_MISS;
    case (w.operation)
      OP_ALLOC: begin
        if (head_free >= SLOTS_DEF) begin
          r.status = ST_FULL;
        end else begin
          s = int'(head_free);
          head_free = next_link[s];
          in_use[s] = 1'b1;
          held_ref[s] = w.payload;
          live_count = live_count + 1'b1;
          r.status = ST_OK;
          r.owner = owner_reg;
          r.handle_slot = HSLOT_W'(s);
          r.handle_version = version_of[s];
        end
      end
      OP_LOOKUP: begin
        if (w.slot_index < SLOTS_DEF) begin
          s = int'(w.slot_index);
          if (in_use[s] && version_of[s] == w.slot_version && held_ref[s] != '0) begin
            r.status = ST_OK;
            r.found_payload = held_ref[s];
          end
        end
      end
      OP_RELEASE: begin
        if (w.payload != '0 && w.slot_index < SLOTS_DEF) begin
          s = int'(w.slot_index);
          if (in_use[s] && held_ref[s] == w.payload) begin
            in_use[s] = 1'b0;
            held_ref[s] = '0;
            version_of[s] = version_of[s] + 1'b1;
            next_link[s] = head_free;
            head_free = COUNT_W'(s);
            live_count = live_count - 1'b1;
            r.status = ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
    r.active_count = live_count;
    return r;
  endfunction

  function automatic logic [PAY_W-1:0] rand_ref();
    logic [PAY_W-1:0] v;
    case ($urandom_range(15))
      0: v = '1;
      1: v = 1;
      default: v = $urandom;
    endcase
    if (v == '0) v = 1;
    return v;
  endfunction

  function automatic logic [SLOT_IN_W-1:0] rand_index();
    if ($urandom_range(1)) return SLOT_IN_W'($urandom_range(SLOTS_DEF - 1));
    return SLOT_IN_W'($urandom);
  endfunction

  function automatic int find_live();
    int start;
    int k;
    int s;
    start = $urandom_range(SLOTS_DEF - 1);
    for (k = 0; k < SLOTS_DEF; k++) begin
      s = (start + k) % SLOTS_DEF;
      if (in_use[s] && held_ref[s] != '0) return s;
    end
    return -1;
  endfunction

  // Enter and leave on a falling edge; push is set once per falling edge.
  task automatic send_word(logic [OP_W-1:0] op, logic [SLOT_IN_W-1:0] idx,
                           logic [VER_W-1:0] ver, logic [PAY_W-1:0] pay);
    item_t w;
    w.operation = op;
    w.slot_index = idx;
    w.slot_version = ver;
    w.payload = pay;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
    pending_results.push_back(table_step(w));
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_owner(logic [OWNER_W-1:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_OWNER_ADDR;
    pwdata <= ($urandom & 32'hFFFF_FF00) | DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    owner_reg = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_directed();
    send_word(OP_LOOKUP, 0, 0, 0);
    send_word(OP_RELEASE, 0, 0, 1);
    send_word(OP_ALLOC, '1, '1, 32'hFFFF_FFFF);
    send_word(OP_ALLOC, 0, 0, 0);
    send_word(OP_LOOKUP, 1, 0, 0);
    send_word(OP_RELEASE, 1, 0, 0);
    send_word(OP_LOOKUP, 0, 0, 0);
    send_word(OP_LOOKUP, 0, 16'hFFFF, 0);
    send_word(OP_LOOKUP, 20'hFFFFF, 0, 0);
    send_word(OP_LOOKUP, SLOT_IN_W'(SLOTS_DEF), 0, 0);
    send_word(OP_RELEASE, 20'hFFFFF, 0, 32'hFFFF_FFFF);
    send_word(OP_RELEASE, SLOT_IN_W'(SLOTS_DEF), 0, 1);
    send_word(OP_RELEASE, 0, 0, 32'h7FFF_FFFF);
    send_word(OP_RELEASE, 0, 0, 32'hFFFF_FFFF);
    send_word(OP_LOOKUP, 0, 0, 0);
    send_word(OP_RELEASE, 0, 0, 32'hFFFF_FFFF);
    send_word(OP_ALLOC, 0, 0, 1);
    send_word(OP_LOOKUP, 0, 1, 0);
    send_word(OP_UNUSED, '1, '1, '1);
    send_word(OP_UNUSED, 0, 0, 0);
    send_word(OP_ALLOC, 0, 0, 32'hA5A5_A5A5);
    send_word(OP_RELEASE, 0, 0, 1);
    send_word(OP_LOOKUP, SLOT_IN_W'(SLOTS_DEF - 1), 0, 0);
  endtask

  task automatic test_random(int n);
    int i;
    int pick;
    int s;
    for (i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      pick = $urandom_range(99);
      s = find_live();
      if (s < 0 && pick >= 30 && pick < 80) pick = 0;
      if (pick < 30) begin
        send_word(OP_ALLOC, SLOT_IN_W'($urandom), VER_W'($urandom),
                  ($urandom_range(19) == 0) ? '0 : rand_ref());
      end else if (pick < 55) begin
        send_word(OP_LOOKUP, SLOT_IN_W'(s), version_of[s], $urandom);
      end else if (pick < 80) begin
        send_word(OP_RELEASE, SLOT_IN_W'(s), VER_W'($urandom), held_ref[s]);
      end else if (pick < 88) begin
        if (s >= 0 && $urandom_range(1))
          send_word(OP_LOOKUP, SLOT_IN_W'(s),
                    version_of[s] ^ (16'd1 << $urandom_range(15)), $urandom);
        else
          send_word(OP_LOOKUP, rand_index(), VER_W'($urandom), $urandom);
      end else if (pick < 94) begin
        if (s >= 0 && $urandom_range(1))
          send_word(OP_RELEASE, SLOT_IN_W'(s), VER_W'($urandom),
                    held_ref[s] ^ (32'd1 << $urandom_range(31)));
        else
          send_word(OP_RELEASE, rand_index(), VER_W'($urandom), rand_ref());
      end else begin
        send_word(OP_W'($urandom), SLOT_IN_W'($urandom), VER_W'($urandom), $urandom);
      end
    end
  endtask

  // A released slot goes back on the head, so the same slot steps through versions.
  task automatic test_slot_reuse();
    int               s;
    int               i;
    logic [PAY_W-1:0] p;
    logic [VER_W-1:0] v0;
    s = int'(head_free);
    p = rand_ref();
    v0 = version_of[s];
    for (i = 0; i < REUSE_ROUNDS; i++) begin
      send_word(OP_ALLOC, SLOT_IN_W'($urandom), VER_W'($urandom), p);
      if (i % 8 == 0) send_word(OP_LOOKUP, SLOT_IN_W'(s), version_of[s], $urandom);
      send_word(OP_RELEASE, SLOT_IN_W'(s), VER_W'($urandom), p);
    end
    send_word(OP_ALLOC, SLOT_IN_W'($urandom), VER_W'($urandom), p);
    send_word(OP_LOOKUP, SLOT_IN_W'(s), v0, $urandom);
    send_word(OP_LOOKUP, SLOT_IN_W'(s), v0 - 1'b1, $urandom);
    send_word(OP_RELEASE, SLOT_IN_W'(s), VER_W'($urandom), p);
  endtask

  always @(negedge clk) pop <= !rst && ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin : check_results
    result_t want;
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_word);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_word.status);
          mismatches++;
        end
        if (out_word.owner !== want.owner) begin
          $display("%0t: owner expected %0d got %0d", $time, want.owner, out_word.owner);
          mismatches++;
        end
        if (out_word.handle_slot !== want.handle_slot) begin
          $display("%0t: handle_slot expected %0d got %0d", $time,
                   want.handle_slot, out_word.handle_slot);
          mismatches++;
        end
        if (out_word.handle_version !== want.handle_version) begin
          $display("%0t: handle_version expected %0d got %0d", $time,
                   want.handle_version, out_word.handle_version);
          mismatches++;
        end
        if (out_word.found_payload !== want.found_payload) begin
          $display("%0t: found_payload expected %h got %h", $time,
                   want.found_payload, out_word.found_payload);
          mismatches++;
        end
        if (out_word.active_count !== want.active_count) begin
          $display("%0t: active_count expected %0d got %0d", $time,
                   want.active_count, out_word.active_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    in_word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle = 9;
    recv_idle = 73;
    mismatches = 0;
    cycle_count = 0;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      next_link[i] = COUNT_W'(i + 1);
      in_use[i] = 1'b0;
      version_of[i] = '0;
      held_ref[i] = '0;
    end
    head_free = '0;
    live_count = '0;
    owner_reg = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    set_owner('1);
    test_random(150);

    send_idle = 73;
    recv_idle = 9;
    set_owner(OWNER_W'($urandom));
    test_random(120);

    send_idle = 0;
    recv_idle = 0;
    set_owner(8'h5A);
    test_slot_reuse();
    set_owner(OWNER_W'($urandom));
    test_random(60);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
